>>> hw/rtl/bms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary mask smoothing package
// Sizes, codes, record types and helper functions shared by the smoothing
// block, its line buffer, its window cells and its checker.
// ----------------------------------------------------------------------------
package bms_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int COL_W         = $clog2(MAX_WIDTH);
    localparam int ROW_W         = $clog2(MAX_HEIGHT);
    localparam int CFG_W         = 11;
    localparam int DIM_RESET     = 64;

    localparam int TDATA_W       = 8;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    // Window: the incoming column plus the columns held in the cell chain.
    localparam int COL_BITS      = 3;
    localparam int NUM_COL_CELLS = 2;
    localparam int WIN_BITS      = COL_BITS * (NUM_COL_CELLS + 1);
    localparam int CENTER_BIT    = WIN_BITS / 2;
    localparam int CNT_W         = $clog2(WIN_BITS);
    localparam int KEEP_MIN      = 3;
    localparam int FILL_MIN      = 7;

    // Bit positions inside one line buffer word.
    localparam int LB_UPPER      = 0;
    localparam int LB_MIDDLE     = 1;

    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_DRAIN = 1'b1
    } mode_t;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic shift;
        logic clear;
        logic interior;
    } win_ctrl_t;

    typedef struct packed {
        logic             is_pixel;
        logic             emit;
        logic             interior;
        logic             px;
        logic             last;
        logic             sel_upper;
        logic [COL_W-1:0] addr;
    } stage_t;

    // Index of the last column for a programmed width, with zero read as one
    // and anything above the maximum read as the maximum.
    function automatic logic [COL_W-1:0] last_col(logic [CFG_W-1:0] v);
        if (v == '0) begin
            return '0;
        end else if (int'(v) > MAX_WIDTH) begin
            return COL_W'(MAX_WIDTH - 1);
        end else begin
            return COL_W'(v - CFG_W'(1));
        end
    endfunction

    function automatic logic [ROW_W-1:0] last_row(logic [CFG_W-1:0] v);
        if (v == '0) begin
            return '0;
        end else if (int'(v) > MAX_HEIGHT) begin
            return ROW_W'(MAX_HEIGHT - 1);
        end else begin
            return ROW_W'(v - CFG_W'(1));
        end
    endfunction

endpackage

>>> hw/rtl/bms_line_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line buffer RAM
// Holds the upper and middle row bits of each column in one two-bit word.
// One write and one registered read per cycle, with write-to-read bypass.
// ----------------------------------------------------------------------------
module bms_line_ram (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      rd_en,
    input  logic [bms_pkg::COL_W-1:0] rd_addr,
    input  logic                      wr_en,
    input  logic [bms_pkg::COL_W-1:0] wr_addr,
    input  logic [1:0]                wr_data,
    output logic [1:0]                rd_data
);
    import bms_pkg::*;

    logic [1:0] line_mem [MAX_WIDTH];
    logic [1:0] rd_q_reg;
    logic       byp_reg;
    logic [1:0] byp_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_q_reg     <= line_mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // A read that meets a write to the same column in the same cycle must
    // see the new word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else if (rd_en) begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_q_reg;

endmodule

>>> hw/rtl/bms_col_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window column cell
// Holds one three-pixel column of the window and passes it on to the next
// cell whenever a pixel shifts in.
// ----------------------------------------------------------------------------
module bms_col_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         shift_en,
    input  logic                         clear,
    input  logic [bms_pkg::COL_BITS-1:0] col_in,
    output logic [bms_pkg::COL_BITS-1:0] col_out
);
    import bms_pkg::*;

    logic [COL_BITS-1:0] col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (clear) begin
            col_reg <= '0;
        end else if (shift_en) begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

>>> hw/rtl/bms_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothing window
// A chain of column cells forms the 3x3 neighborhood together with the
// incoming column; the neighbor count decides the smoothed center pixel.
// ----------------------------------------------------------------------------
module bms_window (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bms_pkg::win_ctrl_t           ctrl,
    input  logic [bms_pkg::COL_BITS-1:0] col_in,
    output logic                         pixel_out
);
    import bms_pkg::*;

    logic [COL_BITS-1:0] chain [NUM_COL_CELLS+1];
    logic [WIN_BITS-1:0] win;
    logic [CNT_W-1:0]    cnt;
    logic                center;

    assign chain[0] = col_in;

    for (genvar k = 0; k < NUM_COL_CELLS; k++) begin : g_cell
        bms_col_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (ctrl.shift),
            .clear    (ctrl.clear),
            .col_in   (chain[k]),
            .col_out  (chain[k+1])
        );
    end

    // Newest column sits in the lowest bits, upper row first.
    always_comb begin
        for (int k = 0; k <= NUM_COL_CELLS; k++) begin
            win[k*COL_BITS +: COL_BITS] = chain[k];
        end
    end

    always_comb begin
        cnt = '0;
        for (int i = 0; i < WIN_BITS; i++) begin
            if (i != CENTER_BIT) begin
                cnt = cnt + CNT_W'(win[i]);
            end
        end
    end

    assign center = win[CENTER_BIT];

    always_comb begin
        if (!ctrl.interior) begin
            pixel_out = center;
        end else if (center) begin
            pixel_out = (cnt >= CNT_W'(KEEP_MIN));
        end else begin
            pixel_out = (cnt >= CNT_W'(FILL_MIN));
        end
    end

endmodule

>>> hw/rtl/binary_mask_smoothing_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary mask 3x3 smoothing
// One neighbor-count smoothing pass over a raster-ordered binary mask.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_ stream, one per transaction, row by row; s_tuser
//   selects a pixel or a drain tick. Each smoothed pixel leaves on the m_
//   stream one row plus one pixel behind its input position. Once the frame
//   is complete, one drain tick per pending pixel flushes the tail, and the
//   final pixel of the frame carries m_tlast. Pixels after a complete frame
//   and drain ticks before it are taken and dropped.
//   frame_width and frame_height are written over APB while the stream is
//   idle; a write abandons the frame in progress.
// Timing:
//   One transaction per cycle on either side while m_tready is high. A
//   result reaches the m_ side by way of the read stage and then the output
//   register: the accepting edge registers the line buffer read, and the
//   output register then loads the result from the read stage.
// Reset and stalls:
//   Reset restores 64 x 64 and clears the position counters and the window;
//   the line buffers keep their contents and need no clearing pass.
//   While m_tready is low one result waits in the output register and one
//   more item is held in the read stage; only then does s_tready drop.
// ----------------------------------------------------------------------------
module binary_mask_smoothing_3x3 (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bms_pkg::TDATA_W-1:0]  s_tdata,   // [0] pixel_in
    input  logic [0:0]                   s_tuser,   // [0] mode
    // Result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bms_pkg::TDATA_W-1:0]  m_tdata,   // [0] pixel_out
    output logic                         m_tlast,   // last_out
    // Configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bms_pkg::APB_AW-1:0]   paddr,
    input  logic [bms_pkg::APB_DW-1:0]   pwdata,
    output logic [bms_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import bms_pkg::*;

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic             cfg_wr;
    reg_index_t       cfg_index;

    logic [COL_W-1:0] w_last;
    logic [ROW_W-1:0] h_last;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             full_reg, full_next;
    logic             tail_reg, tail_next;

    logic             in_accept;
    mode_t            in_mode;
    logic             s0_act;
    stage_t           s0_rec;

    logic             s1_valid_reg, s1_valid_next;
    stage_t           s1_reg, s1_next;
    logic             s1_out;
    logic             s1_fire;
    logic             adv1;

    logic [1:0]       rd_data;
    logic [1:0]       wr_data;
    win_ctrl_t        win_ctrl;
    logic [COL_BITS-1:0] win_col;
    logic             win_pixel;
    logic             result;

    logic             m_tvalid_reg, m_tvalid_next;
    logic             m_pixel_reg;
    logic             m_tlast_reg;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[APB_AW-1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= CFG_W'(DIM_RESET);
            frame_height_reg <= CFG_W'(DIM_RESET);
        end else if (cfg_wr) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height_reg);
        endcase
    end

    assign w_last = last_col(frame_width_reg);
    assign h_last = last_row(frame_height_reg);

    // ---------------- input stage: raster position ----------------
    assign in_accept = s_tvalid && s_tready;
    assign in_mode   = mode_t'(s_tuser[0]);

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        full_next = full_reg;
        tail_next = tail_reg;
        s0_act    = 1'b0;
        s0_rec    = '0;
        s0_rec.addr = col_reg;

        if (in_accept) begin
            unique case (in_mode)
                MODE_PIXEL: begin
                    if (!full_reg) begin
                        s0_act          = 1'b1;
                        s0_rec.is_pixel = 1'b1;
                        s0_rec.px       = s_tdata[0];
                        s0_rec.emit     = (row_reg != '0) &&
                                          !(row_reg == ROW_W'(1) && col_reg == '0);
                        s0_rec.interior = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
                        if (col_reg == w_last) begin
                            col_next = '0;
                            if (row_reg == h_last) begin
                                row_next  = '0;
                                full_next = 1'b1;
                                // With two or more rows, the last pixel of the
                                // second-to-last row is still pending.
                                tail_next = (h_last != '0);
                            end else begin
                                row_next = row_reg + ROW_W'(1);
                            end
                        end else begin
                            col_next = col_reg + COL_W'(1);
                        end
                    end
                end
                MODE_DRAIN: begin
                    if (full_reg) begin
                        s0_act = 1'b1;
                        if (tail_reg) begin
                            s0_rec.sel_upper = 1'b1;
                            s0_rec.addr      = w_last;
                            tail_next        = 1'b0;
                        end else begin
                            s0_rec.last = (col_reg == w_last);
                            if (col_reg == w_last) begin
                                col_next  = '0;
                                full_next = 1'b0;
                            end else begin
                                col_next = col_reg + COL_W'(1);
                            end
                        end
                    end
                end
            endcase
        end

        if (cfg_wr) begin
            col_next  = '0;
            row_next  = '0;
            full_next = 1'b0;
            tail_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            full_reg <= 1'b0;
            tail_reg <= 1'b0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            full_reg <= full_next;
            tail_reg <= tail_next;
        end
    end

    // ---------------- read stage ----------------
    assign s1_out   = s1_valid_reg && (!s1_reg.is_pixel || s1_reg.emit);
    assign adv1     = !s1_out || !m_tvalid_reg || m_tready;
    assign s_tready = adv1;
    assign s1_fire  = s1_valid_reg && adv1;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        if (adv1) begin
            s1_valid_next = s0_act;
            s1_next       = s0_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_reg <= s1_next;
    end

    // The middle row moves up and the new pixel becomes the middle row.
    always_comb begin
        wr_data            = '0;
        wr_data[LB_UPPER]  = rd_data[LB_MIDDLE];
        wr_data[LB_MIDDLE] = s1_reg.px;
    end

    bms_line_ram u_line_ram (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (in_accept && s0_act),
        .rd_addr  (s0_rec.addr),
        .wr_en    (s1_fire && s1_reg.is_pixel),
        .wr_addr  (s1_reg.addr),
        .wr_data  (wr_data),
        .rd_data  (rd_data)
    );

    assign win_ctrl.shift    = s1_fire && s1_reg.is_pixel;
    assign win_ctrl.clear    = cfg_wr || (s1_fire && !s1_reg.is_pixel && s1_reg.last);
    assign win_ctrl.interior = s1_reg.interior;
    assign win_col           = {s1_reg.px, rd_data[LB_MIDDLE], rd_data[LB_UPPER]};

    bms_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (win_ctrl),
        .col_in    (win_col),
        .pixel_out (win_pixel)
    );

    always_comb begin
        if (s1_reg.is_pixel) begin
            result = win_pixel;
        end else if (s1_reg.sel_upper) begin
            result = rd_data[LB_UPPER];
        end else begin
            result = rd_data[LB_MIDDLE];
        end
    end

    // ---------------- output register ----------------
    always_comb begin
        if (s1_fire && s1_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_out) begin
            m_pixel_reg <= result;
            m_tlast_reg <= s1_reg.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(m_pixel_reg);
    assign m_tlast  = m_tlast_reg;

endmodule

>>> hw/rtl/bms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothing block port checker
// Watches the stream ports of the smoothing block over time; attached to the
// top level by the bind statement at the end of this file.
// ----------------------------------------------------------------------------
module bms_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [0:0]                  s_tuser,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [bms_pkg::TDATA_W-1:0] m_tdata,
    input logic                        m_tlast
);
    import bms_pkg::*;

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // The padding bits above the pixel stay zero.
    a_out_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[TDATA_W-1:1] == '0))
        else $error("result padding not zero");

    // A fresh result always comes from an earlier input transaction, by way of the read stage.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a matching input transaction");

    // The frame end is only ever produced by a drain tick.
    a_last_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) && m_tlast |-> $past(s_tuser[0] == MODE_DRAIN, 2))
        else $error("frame end flagged on a pixel transaction");

endmodule

bind binary_mask_smoothing_3x3 bms_checker u_bms_checker (.*);
